FILE: rtl/wbgs_pkg.sv
// ----------------------------------------------------------------------------
// wbgs_pkg
// Shared constants and types for the wrapped bilinear grid sampler.
// ----------------------------------------------------------------------------
package wbgs_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 7;
    localparam int COORD_W         = 32;
    localparam int VALUE_W         = 32;
    localparam int WCOORD_W        = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLUMNS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS    = 1'b1;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic                func;
        logic [COORD_W-1:0]  x_coord;
        logic [COORD_W-1:0]  y_coord;
        logic [WCOORD_W-1:0] write_column;
        logic [WCOORD_W-1:0] write_row;
        logic [VALUE_W-1:0]  write_value;
    } req_t;

endpackage

FILE: rtl/wbgs_if.sv
// ----------------------------------------------------------------------------
// wbgs_req_if / wbgs_rsp_if
// Valid/ready channels for requests and sample results.
// ----------------------------------------------------------------------------
interface wbgs_req_if;
    import wbgs_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface wbgs_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

FILE: rtl/wbgs_ram.sv
// ----------------------------------------------------------------------------
// wbgs_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module wbgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

FILE: rtl/wrapped_bilinear_grid_sampler.sv
// ----------------------------------------------------------------------------
// wrapped_bilinear_grid_sampler
// Toroidally wrapped bilinear sampler over a single-port field memory.
// ----------------------------------------------------------------------------
// Write request: stored at the accepting edge.
// Sample request: from accept to result valid, 17 wrap remainder steps, index
// setup, four reads on the one RAM port, two x and one y 33x17 lerp steps and
// output; no new request until back in idle; the y step holds while a result waits.
// Reset (async, active low) clears the FSM and sets both sizes to 64; the
// field memory is not cleared and holds garbage until written.
module wrapped_bilinear_grid_sampler (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [wbgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wbgs_pkg::CFG_DATA_W-1:0] cfg_data,
    wbgs_req_if.sink                        req,
    wbgs_rsp_if.source                      rsp
);
    import wbgs_pkg::*;

    localparam int MAX_COLUMNS = DEF_MAX_COLUMNS;
    localparam int MAX_ROWS    = DEF_MAX_ROWS;
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int IW    = 17; // integer part of offset coordinate, signed
    localparam int SW    = IW + CFG_DATA_W;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_WRAP  = 9'b000000010,
        S_RD0   = 9'b000000100,
        S_RD1   = 9'b000001000,
        S_RD2   = 9'b000010000,
        S_RD3   = 9'b000100000,
        S_LX    = 9'b001000000,
        S_LY    = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [CFG_DATA_W-1:0] ncol_reg, nrow_reg;

    // clamp sizes to 2..MAX
    logic [CFG_DATA_W-1:0] nc_eff, nr_eff;
    always_comb
    begin
        nc_eff = ncol_reg;
        if (ncol_reg < CFG_DATA_W'(2)) nc_eff = CFG_DATA_W'(2);
        else if ({25'd0, ncol_reg} > MAX_COLUMNS) nc_eff = CFG_DATA_W'(MAX_COLUMNS);
        nr_eff = nrow_reg;
        if (nrow_reg < CFG_DATA_W'(2)) nr_eff = CFG_DATA_W'(2);
        else if ({25'd0, nrow_reg} > MAX_ROWS) nr_eff = CFG_DATA_W'(MAX_ROWS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncol_reg <= CFG_DATA_W'(64);
            nrow_reg <= CFG_DATA_W'(64);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_NUM_COLUMNS) ncol_reg <= cfg_data;
            if (cfg_index == CFG_NUM_ROWS)    nrow_reg <= cfg_data;
        end
    end

    // offset coordinates: 33-bit sum, floor = upper 17 bits, fraction = low 16
    logic signed [32:0] xs, ys;
    assign xs = $signed({req.data.x_coord[31], req.data.x_coord}) + 33'sd32768;
    assign ys = $signed({req.data.y_coord[31], req.data.y_coord}) + 33'sd32768;

    logic [15:0] tx_reg, ty_reg;
    logic [CFG_DATA_W-1:0] lx_reg, ly_reg, ux_reg, uy_reg;

    // wrap: reduce the floor magnitude mod the size, one restoring-remainder
    // bit per cycle, then fold negative values back into 0..n-1
    logic [IW:0] mx_reg, my_reg;      // running remainder magnitude
    logic [4:0]  wstep_reg;
    logic        xneg_reg, yneg_reg;

    logic [SW-1:0] rx_try, ry_try;
    logic [SW-1:0] divx_shift, divy_shift;
    assign divx_shift = {{(SW-CFG_DATA_W){1'b0}}, nc_eff} << wstep_reg;
    assign divy_shift = {{(SW-CFG_DATA_W){1'b0}}, nr_eff} << wstep_reg;
    assign rx_try = {{(SW-IW-1){1'b0}}, mx_reg} - divx_shift;
    assign ry_try = {{(SW-IW-1){1'b0}}, my_reg} - divy_shift;

    logic [CFG_DATA_W-1:0] rx_fin, ry_fin, lx_w, ly_w;
    assign rx_fin = mx_reg[CFG_DATA_W-1:0];
    assign ry_fin = my_reg[CFG_DATA_W-1:0];
    assign lx_w = (xneg_reg && rx_fin != '0) ? nc_eff - rx_fin : rx_fin;
    assign ly_w = (yneg_reg && ry_fin != '0) ? nr_eff - ry_fin : ry_fin;

    // RAM
    logic              ram_we;
    logic [AW-1:0]     ram_addr;
    logic [VALUE_W-1:0] ram_rdata;

    wbgs_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (req.data.write_value),
        .rdata (ram_rdata)
    );

    logic wr_ok;
    assign wr_ok = ({26'd0, req.data.write_column} < MAX_COLUMNS)
                && ({26'd0, req.data.write_row} < MAX_ROWS);

    logic req_fire;
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;
    assign ram_we    = req_fire && (req.data.func == FUNC_WRITE) && wr_ok;

    // reads issue from RD1 on; each word comes back through the RAM read register
    always_comb
    begin
        ram_addr = {req.data.write_row[RW-1:0], req.data.write_column[CW-1:0]};
        case (state_reg)
            S_RD1:   ram_addr = {ly_reg[RW-1:0], lx_reg[CW-1:0]};
            S_RD2:   ram_addr = {ly_reg[RW-1:0], ux_reg[CW-1:0]};
            S_RD3:   ram_addr = {uy_reg[RW-1:0], lx_reg[CW-1:0]};
            S_LX:    ram_addr = {uy_reg[RW-1:0], ux_reg[CW-1:0]};
            default: ram_addr = {req.data.write_row[RW-1:0],
                                 req.data.write_column[CW-1:0]};
        endcase
    end

    // interpolation: a + floor((b-a)*t / 65536), one multiply per step
    logic signed [VALUE_W-1:0] ll_reg, lr_reg, ul_reg, lower_reg, upper_reg;
    logic signed [VALUE_W-1:0] lerp_a, lerp_b;
    logic [15:0]               lerp_t;
    logic signed [32:0]        diff;
    logic signed [49:0]        prod;
    logic signed [VALUE_W-1:0] lerp_res;
    assign diff     = $signed({lerp_b[31], lerp_b}) - $signed({lerp_a[31], lerp_a});
    assign prod     = diff * $signed({1'b0, lerp_t});
    assign lerp_res = lerp_a + VALUE_W'(prod >>> 16);

    logic [1:0] lstep_reg;
    logic signed [VALUE_W-1:0] out_reg;
    logic out_valid_reg;
    logic out_free;
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        lerp_t = tx_reg;
        lerp_a = ll_reg;
        lerp_b = lr_reg;
        case (lstep_reg)
            2'd1:    begin lerp_a = ul_reg;    lerp_b = ram_rdata; end
            2'd2:    begin lerp_a = lower_reg; lerp_b = upper_reg; lerp_t = ty_reg; end
            default: begin lerp_a = ll_reg;    lerp_b = lr_reg; end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (req_fire && req.data.func == FUNC_SAMPLE) state_next = S_WRAP;
            S_WRAP:  if (wstep_reg == 5'd0) state_next = S_RD0;
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RD3;
            S_RD3:   state_next = S_LX;
            S_LX:    if (lstep_reg == 2'd1) state_next = S_LY;
            S_LY:    if (out_free) state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    logic [IW-1:0] fx_mag, fy_mag;
    assign fx_mag = xs[32] ? IW'(-xs[32:16]) : xs[32:16];
    assign fy_mag = ys[32] ? IW'(-ys[32:16]) : ys[32:16];

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                tx_reg    <= xs[15:0];
                ty_reg    <= ys[15:0];
                xneg_reg  <= xs[32];
                yneg_reg  <= ys[32];
                mx_reg    <= {1'b0, fx_mag};
                my_reg    <= {1'b0, fy_mag};
                wstep_reg <= 5'(IW - 1);
                lstep_reg <= 2'd0;
            end
            S_WRAP:
            begin
                // one restoring-remainder bit per cycle on both axes
                if (!rx_try[SW-1]) mx_reg <= rx_try[IW:0];
                if (!ry_try[SW-1]) my_reg <= ry_try[IW:0];
                if (wstep_reg != 5'd0) wstep_reg <= wstep_reg - 5'd1;
            end
            S_RD0:
            begin
                lx_reg <= lx_w;
                ly_reg <= ly_w;
                ux_reg <= (lx_w + 1'b1 == nc_eff) ? '0 : lx_w + 1'b1;
                uy_reg <= (ly_w + 1'b1 == nr_eff) ? '0 : ly_w + 1'b1;
            end
            S_RD2:   ll_reg <= ram_rdata;
            S_RD3:   lr_reg <= ram_rdata;
            S_LX:
            begin
                if (lstep_reg == 2'd0)
                begin
                    lower_reg <= lerp_res;
                    ul_reg    <= ram_rdata;
                end
                else
                    upper_reg <= lerp_res;
                lstep_reg <= lstep_reg + 2'd1;
            end
            S_LY:    if (out_free) out_reg <= lerp_res;
            default: ;
        endcase
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.sample_value = out_reg;

    ap_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !req.ready)
        else $error("request accepted while busy");
    ap_out_after_ly: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without interpolation");
    ap_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE)
        else $error("memory write during sample");
endmodule
